// ===== design/ir_timing_frame_comparator_assert.svh =====
// Assertion macros shared by the frame comparator RTL.
`ifndef IR_TIMING_FRAME_COMPARATOR_ASSERT_SVH
`define IR_TIMING_FRAME_COMPARATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/itfc_pkg.sv =====
// Shared constants, register codes and control types of the frame comparator.
`timescale 1ns / 1ps

package itfc_pkg;

   localparam int MAX_CELLS_DEF = 1024;
   localparam int MIN_CELLS     = 8;
   localparam int PCT_SCALE     = 100;

   localparam int TOL_W      = 16;
   localparam int PFX_W      = 11;
   localparam int PCT_W      = 7;
   localparam int DIFF_W     = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // one quotient bit per divider step
   localparam int DIV_STEPS = PCT_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [TOL_W-1:0] MATCH_TOL_RST  = 16'd200;
   localparam logic [TOL_W-1:0] SYNC_TOL_RST   = 16'd300;
   localparam logic [TOL_W-1:0] DIFF_TOL_RST   = 16'd200;
   localparam logic [PFX_W-1:0] PREFIX_RST     = 11'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATCH_TOL = 2'd0,
      CSR_SYNC_TOL  = 2'd1,
      CSR_DIFF_TOL  = 2'd2,
      CSR_PREFIX    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PCT_SIM    = 2'd0,
      PCT_FULL   = 2'd1,
      PCT_PREFIX = 2'd2
   } pct_sel_type;

   typedef struct packed {
      logic        accum;
      logic        div_load;
      pct_sel_type div_sel;
      logic        div_step;
      logic        div_store;
      logic        rsp_load;
   } itfc_cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } itfc_status_type;

endpackage

// ===== design/itfc_ctrl.sv =====
// Sequencer of the frame comparator: accumulate, three divisions, hand off.
`timescale 1ns / 1ps

module itfc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tlast,
   output logic                       req_tready,
   input  itfc_pkg::itfc_status_type  status,
   output itfc_pkg::itfc_cmd_type     cmd
);
   import itfc_pkg::*;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   pct_sel_type       sel_ff;
   logic              ready_ff;

   assign req_tready = ready_ff;

   always_comb begin
      cmd           = '0;
      cmd.div_sel   = sel_ff;
      cmd.accum     = ready_ff & req_tvalid;
      cmd.div_load  = (state_ff == ST_LOAD);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.div_store = (state_ff == ST_DIV) && (step_ff == STEP_W'(DIV_STEPS - 1));
      cmd.rsp_load  = (state_ff == ST_OUT) && !status.rsp_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
         sel_ff   <= PCT_SIM;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_ACCUM: begin
               if (cmd.accum && req_tlast) begin
                  state_ff <= ST_LOAD;
                  sel_ff   <= PCT_SIM;
                  ready_ff <= 1'b0;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_DIV;
               step_ff  <= '0;
            end
            ST_DIV: begin
               if (cmd.div_store) begin
                  unique case (sel_ff)
                     PCT_SIM: begin
                        sel_ff   <= PCT_FULL;
                        state_ff <= ST_LOAD;
                     end
                     PCT_FULL: begin
                        sel_ff   <= PCT_PREFIX;
                        state_ff <= ST_LOAD;
                     end
                     default: begin
                        state_ff <= ST_OUT;
                     end
                  endcase
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_OUT: begin
               if (!status.rsp_busy) begin
                  state_ff <= ST_ACCUM;
                  ready_ff <= 1'b1;
               end
            end
         endcase
      end
   end

endmodule

// ===== design/itfc_dpath.sv =====
// Datapath of the frame comparator: settings, cell counters, divider, result register.
`timescale 1ns / 1ps

module itfc_dpath #(
   parameter int MAX_CELLS = itfc_pkg::MAX_CELLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [itfc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [itfc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [itfc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  itfc_pkg::itfc_cmd_type            cmd,
   output itfc_pkg::itfc_status_type         status,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [itfc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);
   import itfc_pkg::*;

   localparam int CNT_W = $clog2(MAX_CELLS + 1);
   localparam int CW    = (CNT_W > PFX_W) ? CNT_W : PFX_W;
   localparam int NUMW  = CNT_W + PCT_W;
   localparam int PAD_W = RSP_DATA_W - 2 * PCT_W - DIFF_W;

   logic [TOL_W-1:0] match_tol_ff, sync_tol_ff, diff_tol_ff;
   logic [PFX_W-1:0] prefix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_tol_ff <= MATCH_TOL_RST;
         sync_tol_ff  <= SYNC_TOL_RST;
         diff_tol_ff  <= DIFF_TOL_RST;
         prefix_ff    <= PREFIX_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MATCH_TOL: match_tol_ff <= csr_wdata[TOL_W-1:0];
            CSR_SYNC_TOL:  sync_tol_ff  <= csr_wdata[TOL_W-1:0];
            CSR_DIFF_TOL:  diff_tol_ff  <= csr_wdata[TOL_W-1:0];
            CSR_PREFIX:    prefix_ff    <= csr_wdata[PFX_W-1:0];
         endcase
      end
   end

   // per-cell distance and classification
   logic [TOL_W-1:0] first_us, second_us, gap_us;
   logic             room, in_prefix;

   assign first_us  = req_tdata[TOL_W-1:0];
   assign second_us = req_tdata[2*TOL_W-1:TOL_W];
   assign gap_us    = (first_us > second_us) ? (first_us - second_us)
                                             : (second_us - first_us);

   logic [CNT_W-1:0] cell_ff, match_ff, full_ff, pre_ff, differ_ff;

   assign room      = cell_ff < CNT_W'(MAX_CELLS);
   assign in_prefix = CW'(cell_ff) < CW'(prefix_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.rsp_load) begin
         cell_ff   <= '0;
         match_ff  <= '0;
         full_ff   <= '0;
         pre_ff    <= '0;
         differ_ff <= '0;
      end else if (cmd.accum && room) begin
         cell_ff <= cell_ff + 1'b1;
         if (gap_us <= match_tol_ff) begin
            match_ff <= match_ff + 1'b1;
         end
         if (gap_us <= sync_tol_ff) begin
            full_ff <= full_ff + 1'b1;
            if (in_prefix) begin
               pre_ff <= pre_ff + 1'b1;
            end
         end
         if (gap_us > diff_tol_ff) begin
            differ_ff <= differ_ff + 1'b1;
         end
      end
   end

   // restoring divider, one quotient bit per step
   logic [CNT_W-1:0] pn, num, den;
   logic [NUMW-1:0]  rem_ff, dvs_ff, rem_in;
   logic [PCT_W-1:0] q_ff, q_in;
   logic [PCT_W-1:0] sim_q_ff, full_q_ff, pre_q_ff;
   logic             ge;

   assign pn = (CW'(prefix_ff) < CW'(cell_ff)) ? CNT_W'(prefix_ff) : cell_ff;

   always_comb begin
      unique case (cmd.div_sel)
         PCT_SIM: begin
            num = match_ff;
            den = cell_ff;
         end
         PCT_FULL: begin
            num = full_ff;
            den = cell_ff;
         end
         default: begin
            num = pre_ff;
            den = pn;
         end
      endcase
   end

   assign ge     = rem_ff >= dvs_ff;
   assign rem_in = ge ? (rem_ff - dvs_ff) : rem_ff;
   assign q_in   = {q_ff[PCT_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= NUMW'(num) * NUMW'(PCT_SCALE);
         dvs_ff <= NUMW'(den) << (PCT_W - 1);
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvs_ff <= dvs_ff >> 1;
         q_ff   <= q_in;
      end
      if (cmd.div_store) begin
         unique case (cmd.div_sel)
            PCT_SIM:  sim_q_ff  <= q_in;
            PCT_FULL: full_q_ff <= q_in;
            default:  pre_q_ff  <= q_in;
         endcase
      end
   end

   // result register
   logic             too_short;
   logic [PCT_W-1:0] best_sync;
   logic             rsp_valid_ff;
   logic [PCT_W-1:0] sim_ff, sync_ff;
   logic [DIFF_W-1:0] dif_ff;
   logic             short_ff;

   assign too_short = cell_ff < CNT_W'(MIN_CELLS);
   assign best_sync = ((pn == '0) || (full_q_ff > pre_q_ff)) ? full_q_ff : pre_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         sim_ff   <= too_short ? '0 : sim_q_ff;
         sync_ff  <= too_short ? '0 : best_sync;
         dif_ff   <= too_short ? '0 : DIFF_W'(differ_ff);
         short_ff <= too_short;
      end
   end

   assign status.rsp_busy = rsp_valid_ff & ~rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {{PAD_W{1'b0}}, dif_ff, sync_ff, sim_ff};
   assign rsp_tuser       = short_ff;

endmodule

// ===== design/ir_timing_frame_comparator.sv =====
// Top level of the infrared timing frame comparator.
`timescale 1ns / 1ps
`include "ir_timing_frame_comparator_assert.svh"

// Channel  Direction  Word contents (lowest bit up)
// req_     in         tdata: first_cell_us[15:0], second_cell_us[31:16]; tlast: last_cell
// rsp_     out        tdata: similarity_pct[6:0], sync_pct[13:7], differing_cells[24:14];
//                     tuser: too_short
// csr_     in         we / index / wdata: match, sync, diff tolerance, prefix cells
//
// Cells are taken one per cycle while the frame accumulates.
// After the last cell the shared restoring divider runs three quotients,
// each a load and then seven steps, then the result register is loaded;
// req_tready stays low from the last cell until that load.
// A result held by a stalled rsp_ side keeps the next frame's result
// waiting in the divider, and req_tready stays low, so no cells are taken.
// Synchronous active-high reset restores the register defaults and clears
// the counters; configuration writes land whenever csr_we is high.

module ir_timing_frame_comparator #(
   parameter int MAX_CELLS = itfc_pkg::MAX_CELLS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration write port
   input  logic                             csr_we,
   input  logic [itfc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [itfc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // cell pairs
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [itfc_pkg::REQ_DATA_W-1:0]  req_tdata,  // first_cell_us, second_cell_us
   input  logic                             req_tlast,
   // frame scores
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [itfc_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // similarity, sync, differing, pad
   output logic                             rsp_tuser   // too_short
);
   import itfc_pkg::*;

   itfc_cmd_type    cmd;
   itfc_status_type status;

   // sequence accumulation, division and result hand-off
   itfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold settings, count cells, divide, register the word
   itfc_dpath #(
      .MAX_CELLS (MAX_CELLS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a last cell closes the input until the result is loaded
   `ITFC_ASSERT_NEXT(a_last_closes, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "input open after last cell")
   // never overwrite a result word still waiting on the output
   `ITFC_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.rsp_load, !(rsp_tvalid && !rsp_tready), "result overwritten")
   // a loaded result shows on the output next cycle
   `ITFC_ASSERT_NEXT(a_load_shows, clock, reset, cmd.rsp_load, rsp_tvalid, "loaded result not valid")
   // accumulate, divide and hand-off never overlap
   `ITFC_ASSERT_NOW(a_cmd_exclusive, clock, reset, 1'b1, $onehot0({cmd.accum, cmd.div_load, cmd.div_step, cmd.rsp_load}), "overlapping commands")

endmodule
